@@ rtl/sstf_disk_request_scheduler_macros.svh @@
// Assertion helpers used by the scheduler RTL.
`ifndef SSTF_DISK_REQUEST_SCHEDULER_MACROS_SVH
`define SSTF_DISK_REQUEST_SCHEDULER_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define SSTF_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define SSTF_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sstf_pkg.sv @@
`default_nettype none
package sstf_pkg;

    // Default sizes of the pending table and of a stored track number.
    localparam int SSTF_QUEUE_DEPTH = 32;
    localparam int SSTF_TRACK_BITS  = 10;

    // Fixed widths of the port fields.
    localparam int TRK_W = 10;
    localparam int CNT_W = 6;
    localparam int SUM_W = 32;

    // Request modes.
    localparam logic MODE_ADD      = 1'b0;
    localparam logic MODE_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        STAT_ADDED      = 2'd0,
        STAT_DISPATCHED = 2'd1,
        STAT_EMPTY      = 2'd2,
        STAT_FULL       = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_SHIFT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic             mode;
        logic [TRK_W-1:0] track;
    } t_sched_in;

    typedef struct packed {
        t_status          status;
        logic [TRK_W-1:0] served_track;
        logic [TRK_W-1:0] seek_distance;
        logic [SUM_W-1:0] total_movement;
        logic [CNT_W-1:0] pending_count;
    } t_sched_out;

endpackage
`default_nettype wire

@@ rtl/sstf_track_ram.sv @@
`default_nettype none
module sstf_track_ram
    import sstf_pkg::*;
#(
    parameter int DEPTH = SSTF_QUEUE_DEPTH,
    parameter int WIDTH = SSTF_TRACK_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ rtl/sstf_disk_request_scheduler.sv @@
// Channel    Ports                   Handshake
// request    i_req (t_sched_in)      transfer when start is high and busy is low
// result     o_res (t_sched_out)     transfer in each cycle that o_done is high
//
// An add, an add to a full table and a dispatch on an empty table never raise
// busy; their result appears in the cycle after the request transfer.
// A dispatch over N pending entries holds busy through a scan of N reads
// through the single read port of the track RAM, then a shift of the entries
// younger than the chosen one.
// The result appears in the same cycle in which busy falls.
// Reset is synchronous and active low; the receiver cannot stall results.
`default_nettype none
`include "sstf_disk_request_scheduler_macros.svh"
module sstf_disk_request_scheduler
    import sstf_pkg::*;
#(
    parameter int QUEUE_DEPTH = SSTF_QUEUE_DEPTH,
    parameter int TRACK_BITS  = SSTF_TRACK_BITS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire t_sched_in  i_req,
    output logic            busy,
    output logic            o_done,
    output t_sched_out      o_res
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_state                r_state;
    t_state                n_state;
    logic [CW-1:0]         r_count;
    logic [TRACK_BITS-1:0] r_head;
    logic [SUM_W-1:0]      r_sum;
    logic [CW-1:0]         r_idx;
    logic                  r_cmp_vld;
    logic [IW-1:0]         r_cmp_idx;
    logic [IW-1:0]         r_best_idx;
    logic [TRACK_BITS-1:0] r_best_gap;
    logic [TRACK_BITS-1:0] r_best_trk;
    logic                  r_wr_vld;
    logic [IW-1:0]         r_wr_idx;
    logic                  r_res_vld;
    t_sched_out            r_res;

    logic [TRACK_BITS-1:0] w_rdata;
    logic [IW-1:0]         w_raddr;
    logic                  w_we;
    logic [IW-1:0]         w_waddr;
    logic [TRACK_BITS-1:0] w_wdata;

    // Request decode.
    logic w_acc;
    logic w_add;
    logic w_full;
    logic w_empty;
    assign w_acc   = start && !busy;
    assign w_add   = w_acc && (i_req.mode == MODE_ADD);
    assign w_full  = (r_count == CW'(QUEUE_DEPTH));
    assign w_empty = (r_count == '0);

    // Fit the port track number to the stored width.
    logic [TRACK_BITS+TRK_W-1:0] w_in_ext;
    logic [TRACK_BITS-1:0]       w_in_trk;
    assign w_in_ext = {{TRACK_BITS{1'b0}}, i_req.track};
    assign w_in_trk = w_in_ext[TRACK_BITS-1:0];

    // Next index for the scan and shift walks.
    logic [CW-1:0] w_idx_nx;
    assign w_idx_nx = r_idx + CW'(1);

    // Shared compare unit: distance of the entry just read from the head.
    logic [TRACK_BITS-1:0] w_gap;
    logic                  w_take;
    logic [IW-1:0]         n_best_idx;
    assign w_gap      = (r_head > w_rdata) ? (r_head - w_rdata) : (w_rdata - r_head);
    assign w_take     = r_cmp_vld && ((r_cmp_idx == '0) || (w_gap < r_best_gap));
    assign n_best_idx = w_take ? r_cmp_idx : r_best_idx;

    // Saturating running total.
    logic [SUM_W:0] w_sum;
    assign w_sum = {1'b0, r_sum} + (SUM_W + 1)'(r_best_gap);

    // Field fitting for the result.
    logic [TRACK_BITS+TRK_W-1:0] w_srv_ext;
    logic [TRACK_BITS+TRK_W-1:0] w_gap_ext;
    logic [CW+CNT_W-1:0]         w_cnt_inc_ext;
    logic [CW+CNT_W-1:0]         w_cnt_dec_ext;
    logic [CW+CNT_W-1:0]         w_cnt_ext;
    assign w_srv_ext     = {{TRK_W{1'b0}}, r_best_trk};
    assign w_gap_ext     = {{TRK_W{1'b0}}, r_best_gap};
    assign w_cnt_inc_ext = {{CNT_W{1'b0}}, r_count + CW'(1)};
    assign w_cnt_dec_ext = {{CNT_W{1'b0}}, r_count - CW'(1)};
    assign w_cnt_ext     = {{CNT_W{1'b0}}, r_count};

    // Write port: shift moves take the port, otherwise a new request is appended.
    always_comb begin
        if (r_wr_vld) begin
            w_we    = 1'b1;
            w_waddr = r_wr_idx;
            w_wdata = w_rdata;
        end else begin
            w_we    = w_add && !w_full;
            w_waddr = r_count[IW-1:0];
            w_wdata = w_in_trk;
        end
    end

    sstf_track_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (TRACK_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc && (i_req.mode == MODE_DISPATCH) && !w_empty) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_idx_nx == r_count) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (w_idx_nx >= r_count) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        busy    = 1'b1;
        w_raddr = r_idx[IW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_SCAN: begin
                w_raddr = r_idx[IW-1:0];
            end
            ST_SHIFT: begin
                w_raddr = w_idx_nx[IW-1:0];
            end
            ST_LAST, ST_FINISH: begin
                w_raddr = r_idx[IW-1:0];
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_head    <= '0;
            r_sum     <= '0;
            r_cmp_vld <= 1'b0;
            r_wr_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == ST_SCAN);
            r_wr_vld  <= (r_state == ST_SHIFT) && (w_idx_nx < r_count);
            r_res_vld <= (w_acc && ((i_req.mode == MODE_ADD) || w_empty))
                         || (r_state == ST_FINISH);
            if (w_add && !w_full) begin
                r_count <= r_count + CW'(1);
            end
            if (r_state == ST_FINISH) begin
                r_count <= r_count - CW'(1);
                r_head  <= r_best_trk;
                r_sum   <= w_sum[SUM_W] ? {SUM_W{1'b1}} : w_sum[SUM_W-1:0];
            end
        end
    end

    // Scan, compare and shift datapath.
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx[IW-1:0];
        r_wr_idx  <= r_idx[IW-1:0];
        if (w_take) begin
            r_best_idx <= r_cmp_idx;
            r_best_gap <= w_gap;
            r_best_trk <= w_rdata;
        end
        case (r_state)
            ST_IDLE: begin
                r_idx <= '0;
            end
            ST_SCAN: begin
                r_idx <= w_idx_nx;
            end
            ST_LAST: begin
                r_idx <= CW'(n_best_idx);
            end
            ST_SHIFT: begin
                if (w_idx_nx < r_count) begin
                    r_idx <= w_idx_nx;
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH) begin
            r_res.status         <= STAT_DISPATCHED;
            r_res.served_track   <= w_srv_ext[TRK_W-1:0];
            r_res.seek_distance  <= w_gap_ext[TRK_W-1:0];
            r_res.total_movement <= w_sum[SUM_W] ? {SUM_W{1'b1}} : w_sum[SUM_W-1:0];
            r_res.pending_count  <= w_cnt_dec_ext[CNT_W-1:0];
        end else if (w_acc) begin
            r_res.served_track   <= '0;
            r_res.seek_distance  <= '0;
            r_res.total_movement <= r_sum;
            if (i_req.mode == MODE_ADD) begin
                if (w_full) begin
                    r_res.status        <= STAT_FULL;
                    r_res.pending_count <= w_cnt_ext[CNT_W-1:0];
                end else begin
                    r_res.status        <= STAT_ADDED;
                    r_res.pending_count <= w_cnt_inc_ext[CNT_W-1:0];
                end
            end else begin
                r_res.status        <= STAT_EMPTY;
                r_res.pending_count <= w_cnt_ext[CNT_W-1:0];
            end
        end
    end

    assign o_done = r_res_vld;
    assign o_res  = r_res;

    // Checks on the sequencer.
    `SSTF_ASSERT(a_accept_answered, i_clk, i_rst_n, (start && !busy) |=> (o_done || busy), "request transfer neither answered nor started")
    `SSTF_ASSERT(a_done_idle, i_clk, i_rst_n, o_done |-> !busy, "result shown while a dispatch is still in work")
    `SSTF_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(QUEUE_DEPTH), "pending count beyond table depth")
    `SSTF_ASSERT(a_shift_write, i_clk, i_rst_n, r_wr_vld |-> (r_state == ST_SHIFT || r_state == ST_FINISH), "shift write outside the shift walk")
    `SSTF_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!busy && !o_done), "block not idle after reset")

endmodule
`default_nettype wire
